### design/quadratic_root_solver_unit_assert.svh
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define QRS_ASSERT_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("qrs check failed");

// antecedent implies consequent in the same cycle
`define QRS_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("qrs check failed");

`endif

### design/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

   localparam int OUT_WIDTH = 34;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_REPEATED = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_DEGEN    = 2'd3
   } kind_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

### design/qrs_front.sv
`default_nettype none
module qrs_front #(
   parameter int CW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_stall,
   input  wire logic [CW-1:0] in_a,
   input  wire logic [CW-1:0] in_b,
   input  wire logic [CW-1:0] in_c,
   input  wire logic          q_full,
   output logic               push,
   output logic [2+(2*CW+1)+2*CW-1:0] push_data
);
   import qrs_pkg::*;

   localparam int MW = 2 * CW + 1;
   localparam int DW = 2 * CW + 2;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [CW-1:0] a1_ff, b1_ff, c1_ff;
   logic signed [CW-1:0] a2_ff, b2_ff, a3_ff, b3_ff;
   logic signed [2*CW-1:0] bb2_ff, ac2_ff;
   kind_type             kind3_ff, kind3_in;
   logic [MW-1:0]        mag3_ff, mag3_in;
   logic signed [DW-1:0] disc;
   logic                 fen;

   assign fen      = !(v3_ff && q_full);
   assign in_stall = !fen;
   assign push     = v3_ff && fen;

   // discriminant and classification
   always_comb begin
      disc = DW'(bb2_ff) - (DW'(ac2_ff) <<< 2);
      mag3_in = disc[DW-1] ? MW'(-disc) : MW'(disc);
      if (a2_ff == '0) begin
         kind3_in = KIND_DEGEN;
      end else if (disc == '0) begin
         kind3_in = KIND_REPEATED;
      end else if (disc[DW-1]) begin
         kind3_in = KIND_COMPLEX;
      end else begin
         kind3_in = KIND_TWO_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fen) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         a1_ff    <= in_a;
         b1_ff    <= in_b;
         c1_ff    <= in_c;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         bb2_ff   <= b1_ff * b1_ff;
         ac2_ff   <= a1_ff * c1_ff;
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
         kind3_ff <= kind3_in;
         mag3_ff  <= mag3_in;
      end
   end

   assign push_data = {kind3_ff, mag3_ff, b3_ff, a3_ff};

endmodule
`default_nettype wire

### design/qrs_queue.sv
`default_nettype none
module qrs_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data,
   output qrs_pkg::queue_status_type status
);
   import qrs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;

   assign status.full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_data     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule
`default_nettype wire

### design/qrs_back.sv
`default_nettype none
module qrs_back #(
   parameter int CW = 16,
   parameter int F  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      pop,
   input  wire logic [2+(2*CW+1)+2*CW-1:0] in_data,
   output logic      out_valid,
   input  wire logic out_stall,
   output qrs_pkg::kind_type out_kind,
   output logic [qrs_pkg::OUT_WIDTH-1:0] out_first,
   output logic [qrs_pkg::OUT_WIDTH-1:0] out_second
);
   import qrs_pkg::*;

   localparam int MW  = 2 * CW + 1;
   localparam int SW  = CW + 1 + F;
   localparam int RW  = 2 * SW;
   localparam int NW  = CW + F + 2;
   localparam int NSW = NW + 1;
   localparam int DVW = CW + 1;
   localparam int QW  = DVW + NW;
   localparam int EW  = ((NW > OUT_WIDTH) ? NW : OUT_WIDTH) + 1;

   logic ben;
   assign ben = !(out_valid && out_stall);
   assign pop = in_valid && ben;

   // square root pipeline, one result bit per stage
   logic           sq_v_ff    [SW+1];
   kind_type       sq_kind_ff [SW+1];
   logic [CW-1:0]  sq_a_ff    [SW+1];
   logic [CW-1:0]  sq_b_ff    [SW+1];
   logic [RW-1:0]  sq_rad_ff  [SW+1];
   logic [SW+1:0]  sq_rem_ff  [SW+1];
   logic [SW-1:0]  sq_root_ff [SW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (ben) begin
         sq_v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         sq_kind_ff[0] <= kind_type'(in_data[2*CW+MW +: 2]);
         sq_rad_ff[0]  <= RW'(in_data[2*CW +: MW]) << (2 * F);
         sq_b_ff[0]    <= in_data[CW +: CW];
         sq_a_ff[0]    <= in_data[0 +: CW];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [SW+1:0] rem_sh, trial, rem_in;
      logic [SW-1:0] root_in;
      always_comb begin
         rem_sh = {sq_rem_ff[k][SW-1:0], sq_rad_ff[k][RW-1-2*k -: 2]};
         trial  = {sq_root_ff[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {sq_root_ff[k][SW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {sq_root_ff[k][SW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (ben) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (ben) begin
            sq_kind_ff[k+1] <= sq_kind_ff[k];
            sq_a_ff[k+1]    <= sq_a_ff[k];
            sq_b_ff[k+1]    <= sq_b_ff[k];
            sq_rad_ff[k+1]  <= sq_rad_ff[k];
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // numerators, their magnitudes and quotient signs
   logic signed [NSW-1:0] nb, s_ext, n1, n2;
   logic signed [CW+1:0]  two_a;
   logic [NW-1:0]  mag1_in, mag2_in;
   logic           neg1_in, neg2_in, a_neg;
   logic [DVW-1:0] div_in;

   always_comb begin
      a_neg = sq_a_ff[SW][CW-1];
      nb    = -(NSW'(signed'(sq_b_ff[SW])) <<< F);
      s_ext = NSW'(sq_root_ff[SW]);
      two_a = (CW+2)'(signed'(sq_a_ff[SW])) <<< 1;
      div_in = a_neg ? DVW'(-two_a) : DVW'(two_a);
      case (sq_kind_ff[SW])
         KIND_TWO_REAL: begin
            n1 = nb + s_ext;
            n2 = nb - s_ext;
         end
         KIND_COMPLEX: begin
            n1 = nb;
            n2 = s_ext;
         end
         default: begin
            n1 = nb;
            n2 = nb;
         end
      endcase
      mag1_in = n1[NSW-1] ? NW'(-n1) : NW'(n1);
      mag2_in = n2[NSW-1] ? NW'(-n2) : NW'(n2);
      neg1_in = n1[NSW-1] ^ a_neg;
      neg2_in = (sq_kind_ff[SW] == KIND_COMPLEX) ? 1'b0 : (n2[NSW-1] ^ a_neg);
   end

   // two restoring dividers, one quotient bit per stage
   logic           dv_v_ff    [NW+1];
   kind_type       dv_kind_ff [NW+1];
   logic           dv_neg1_ff [NW+1];
   logic           dv_neg2_ff [NW+1];
   logic [DVW-1:0] dv_div_ff  [NW+1];
   logic [QW-1:0]  dv_rq1_ff  [NW+1];
   logic [QW-1:0]  dv_rq2_ff  [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (ben) begin
         dv_v_ff[0] <= sq_v_ff[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         dv_kind_ff[0] <= sq_kind_ff[SW];
         dv_neg1_ff[0] <= neg1_in;
         dv_neg2_ff[0] <= neg2_in;
         dv_div_ff[0]  <= div_in;
         dv_rq1_ff[0]  <= QW'(mag1_in);
         dv_rq2_ff[0]  <= QW'(mag2_in);
      end
   end

   function automatic logic [QW-1:0] div_step(input logic [QW-1:0] rq,
                                              input logic [DVW-1:0] d);
      logic [QW-1:0] t;
      t = {rq[QW-2:0], 1'b0};
      if (t[QW-1 -: DVW] >= d) begin
         t[QW-1 -: DVW] = t[QW-1 -: DVW] - d;
         t[0] = 1'b1;
      end
      return t;
   endfunction

   for (genvar k = 0; k < NW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (ben) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (ben) begin
            dv_kind_ff[k+1] <= dv_kind_ff[k];
            dv_neg1_ff[k+1] <= dv_neg1_ff[k];
            dv_neg2_ff[k+1] <= dv_neg2_ff[k];
            dv_div_ff[k+1]  <= dv_div_ff[k];
            dv_rq1_ff[k+1]  <= div_step(dv_rq1_ff[k], dv_div_ff[k]);
            dv_rq2_ff[k+1]  <= div_step(dv_rq2_ff[k], dv_div_ff[k]);
         end
      end
   end

   // sign, saturation and output register
   function automatic logic [OUT_WIDTH-1:0] finish(input logic [NW-1:0] q,
                                                   input logic neg);
      logic [EW-1:0] qe, lim;
      logic [OUT_WIDTH-1:0] r;
      qe  = EW'(q);
      lim = EW'(1) << (OUT_WIDTH - 1);
      if (neg) begin
         r = (qe > lim) ? OUT_WIDTH'(lim) : OUT_WIDTH'(-qe);
      end else begin
         r = (qe >= lim) ? OUT_WIDTH'(lim - EW'(1)) : OUT_WIDTH'(qe);
      end
      return r;
   endfunction

   logic out_v_ff;
   kind_type out_kind_ff;
   logic [OUT_WIDTH-1:0] out_first_ff, out_second_ff, first_in, second_in;

   always_comb begin
      if (dv_kind_ff[NW] == KIND_DEGEN) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = finish(dv_rq1_ff[NW][NW-1:0], dv_neg1_ff[NW]);
         second_in = finish(dv_rq2_ff[NW][NW-1:0], dv_neg2_ff[NW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (ben) begin
         out_v_ff <= dv_v_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         out_kind_ff   <= dv_kind_ff[NW];
         out_first_ff  <= first_in;
         out_second_ff <= second_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_kind   = out_kind_ff;
   assign out_first  = out_first_ff;
   assign out_second = out_second_ff;

endmodule
`default_nettype wire

### design/quadratic_root_solver_unit.sv
// path from accept to rsp_valid: front registers, queue, square root stages, divider stages, output register
// throughput: one word per cycle while rsp_stall is low; square root and both dividers are fully pipelined
// the whole back pipeline waits on rsp_stall while the four-entry queue keeps the front moving
// reset: synchronous, active high; clears every valid bit and the queue pointers
// payload registers are not reset
`default_nettype none
module quadratic_root_solver_unit #(
   parameter int COEFF_WIDTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [COEFF_WIDTH-1:0] req_coef_a,
   input  wire logic [COEFF_WIDTH-1:0] req_coef_b,
   input  wire logic [COEFF_WIDTH-1:0] req_coef_c,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output qrs_pkg::kind_type rsp_root_kind,
   output logic [qrs_pkg::OUT_WIDTH-1:0] rsp_first_value,
   output logic [qrs_pkg::OUT_WIDTH-1:0] rsp_second_value
);
   import qrs_pkg::*;

   // queue word: kind, discriminant magnitude, b, a
   localparam int QDW = 2 + (2 * COEFF_WIDTH + 1) + 2 * COEFF_WIDTH;

   logic             push, pop;
   logic [QDW-1:0]   push_data, pop_data;
   queue_status_type q_st;

   // front: coefficient products, discriminant, root class
   qrs_front #(.CW(COEFF_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_a      (req_coef_a),
      .in_b      (req_coef_b),
      .in_c      (req_coef_c),
      .q_full    (q_st.full),
      .push      (push),
      .push_data (push_data)
   );

   // short queue decouples front stalls from back stalls
   qrs_queue #(.W(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_st)
   );

   // back: square root, two dividers, saturation, output register
   qrs_back #(.CW(COEFF_WIDTH), .F(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!q_st.empty),
      .pop        (pop),
      .in_data    (pop_data),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_kind   (rsp_root_kind),
      .out_first  (rsp_first_value),
      .out_second (rsp_second_value)
   );

   `include "quadratic_root_solver_unit_assert.svh"

   // queue never reports full and empty together
   `QRS_ASSERT_NEVER(a_queue_status, q_st.full && q_st.empty)
   // degenerate words carry zero values
   `QRS_ASSERT_IMPLY(a_degen_zero, rsp_valid && rsp_root_kind == KIND_DEGEN, rsp_first_value == '0 && rsp_second_value == '0)
   // imaginary magnitude is never negative
   `QRS_ASSERT_IMPLY(a_imag_sign, rsp_valid && rsp_root_kind == KIND_COMPLEX, !rsp_second_value[OUT_WIDTH-1])

endmodule
`default_nettype wire
